// File: rtl/bctd_pkg.sv
// ----------------------------------------------------------------------------
// bctd_pkg: shared types and constants of the texture block decoder
// Block format codes, the decoded block record that passes from the front
// end to the pixel streamer, and constant-divisor helpers.
// ----------------------------------------------------------------------------
package bctd_pkg;

  // Block format codes on the kind input. Code 3 decodes as BC3.
  localparam logic [1:0] KIND_BC1 = 2'd0;
  localparam logic [1:0] KIND_BC2 = 2'd1;
  localparam logic [1:0] KIND_BC3 = 2'd2;

  // Reciprocal multipliers for truncating division by small constants.
  // Each is exact over the range of sums that reaches it.
  localparam logic [15:0] DIV3_MUL = 16'd171;   // 2^9 / 3, rounded up
  localparam logic [23:0] DIV5_MUL = 24'd6554;  // 2^15 / 5, rounded up
  localparam logic [23:0] DIV7_MUL = 24'd4682;  // 2^15 / 7, rounded up

  // Decoded block: palettes ready, raw index words kept for the streamer.
  typedef struct packed {
    logic [1:0]        kind;
    logic              three_mode;
    logic [3:0][15:0]  pal;
    logic [7:0][7:0]   apal;
    logic [31:0]       cidx;
    logic [63:0]       aw;
  } blk_t;

  // Truncating divide by 3 of a colour channel sum (at most 189).
  function automatic logic [5:0] div3(input logic [7:0] x);
    logic [15:0] prod;
    prod = {8'd0, x} * DIV3_MUL;
    return prod[14:9];
  endfunction

  // Truncating divide by 5 of an alpha sum (at most 1275).
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] prod;
    prod = {13'd0, x} * DIV5_MUL;
    return prod[22:15];
  endfunction

  // Truncating divide by 7 of an alpha sum (at most 1785).
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] prod;
    prod = {13'd0, x} * DIV7_MUL;
    return prod[22:15];
  endfunction

endpackage

// File: rtl/bctd_front.sv
// ----------------------------------------------------------------------------
// bctd_front: block classifier and palette builder
// Two-stage pipeline: the first stage classifies the block and forms the
// weighted channel and alpha sums, the second divides them into palettes.
// ----------------------------------------------------------------------------
module bctd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [15:0]         endpoint_a,
  input  logic [15:0]         endpoint_b,
  input  logic [31:0]         color_indices,
  input  logic [63:0]         alpha_word,
  output logic                blk_valid,
  input  logic                blk_ready,
  output bctd_pkg::blk_t      blk
);

  typedef struct packed {
    logic [1:0]        kind;
    logic              three_mode;
    logic              six_mode;
    logic [15:0]       ca;
    logic [15:0]       cb;
    logic [31:0]       cidx;
    logic [63:0]       aw;
    logic [2:0][7:0]   sum2;
    logic [2:0][7:0]   sum3;
    logic [5:0][10:0]  asum;
  } stage_a_t;

  stage_a_t        sa;
  stage_a_t        sa_next;
  logic            sa_valid;
  logic            sb_valid;
  bctd_pkg::blk_t  sb;
  bctd_pkg::blk_t  sb_next;
  logic            sa_free;
  logic            sb_free;

  // Pipeline flow: each stage loads when it is empty or is draining.
  assign sb_free   = !sb_valid || blk_ready;
  assign sa_free   = !sa_valid || sb_free;
  assign in_ready  = sa_free;
  assign blk_valid = sb_valid;
  assign blk       = sb;

  // First stage: mode selection and weighted sums.
  always_comb begin
    logic [2:0][7:0] ch_a;
    logic [2:0][7:0] ch_b;
    logic [7:0]      a0;
    logic [7:0]      a1;
    ch_a = {3'd0, endpoint_a[15:11], 2'd0, endpoint_a[10:5], 3'd0, endpoint_a[4:0]};
    ch_b = {3'd0, endpoint_b[15:11], 2'd0, endpoint_b[10:5], 3'd0, endpoint_b[4:0]};
    a0   = alpha_word[7:0];
    a1   = alpha_word[15:8];
    sa_next.kind       = kind;
    sa_next.three_mode = (kind == bctd_pkg::KIND_BC1) && !(endpoint_a > endpoint_b);
    sa_next.six_mode   = a0 > a1;
    sa_next.ca         = endpoint_a;
    sa_next.cb         = endpoint_b;
    sa_next.cidx       = color_indices;
    sa_next.aw         = alpha_word;
    for (int c = 0; c < 3; c++) begin
      if (sa_next.three_mode) begin
        sa_next.sum2[c] = ch_a[c] + ch_b[c];
      end else begin
        sa_next.sum2[c] = {ch_a[c][6:0], 1'b0} + ch_b[c];
      end
      sa_next.sum3[c] = ch_a[c] + {ch_b[c][6:0], 1'b0};
    end
    for (int k = 1; k <= 6; k++) begin
      if (sa_next.six_mode) begin
        sa_next.asum[k-1] = 11'(7 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
      end else if (k <= 4) begin
        sa_next.asum[k-1] = 11'(5 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
      end else begin
        sa_next.asum[k-1] = '0;
      end
    end
  end

  // Second stage: constant divides and palette assembly.
  always_comb begin
    logic [2:0][5:0] q2;
    logic [2:0][5:0] q3;
    for (int c = 0; c < 3; c++) begin
      q2[c] = sa.three_mode ? sa.sum2[c][6:1] : bctd_pkg::div3(sa.sum2[c]);
      q3[c] = bctd_pkg::div3(sa.sum3[c]);
    end
    sb_next.kind       = sa.kind;
    sb_next.three_mode = sa.three_mode;
    sb_next.cidx       = sa.cidx;
    sb_next.aw         = sa.aw;
    sb_next.pal[0]     = sa.ca;
    sb_next.pal[1]     = sa.cb;
    sb_next.pal[2]     = {q2[2][4:0], q2[1][5:0], q2[0][4:0]};
    sb_next.pal[3]     = sa.three_mode ? 16'd0 : {q3[2][4:0], q3[1][5:0], q3[0][4:0]};
    sb_next.apal[0]    = sa.aw[7:0];
    sb_next.apal[1]    = sa.aw[15:8];
    for (int k = 1; k <= 6; k++) begin
      if (sa.six_mode) begin
        sb_next.apal[k+1] = bctd_pkg::div7(sa.asum[k-1]);
      end else if (k <= 4) begin
        sb_next.apal[k+1] = bctd_pkg::div5(sa.asum[k-1]);
      end else if (k == 5) begin
        sb_next.apal[k+1] = 8'd0;
      end else begin
        sb_next.apal[k+1] = 8'd255;
      end
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
    end else begin
      if (sa_free) begin
        sa_valid <= in_valid;
      end
      if (sb_free) begin
        sb_valid <= sa_valid;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (sa_free) begin
      sa <= sa_next;
    end
    if (sb_free) begin
      sb <= sb_next;
    end
  end

endmodule

// File: rtl/bctd_queue.sv
// ----------------------------------------------------------------------------
// bctd_queue: decoded block queue
// Small circular buffer of decoded blocks between the front end and the
// pixel streamer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bctd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bctd_pkg::blk_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bctd_pkg::blk_t  rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bctd_pkg::blk_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Occupancy stays within the buffer.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("bctd_queue: occupancy exceeds depth");

  // A full queue takes no write, an empty one gives no read.
  assert property (@(posedge clk) disable iff (rst) (count == CW'(DEPTH)) |-> !push)
    else $error("bctd_queue: write into full queue");

  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> !pop)
    else $error("bctd_queue: read from empty queue");

  assert property (@(posedge clk) disable iff (rst) push && !pop |=> count != '0)
    else $error("bctd_queue: write lost");

endmodule

// File: rtl/bctd_back.sv
// ----------------------------------------------------------------------------
// bctd_back: pixel streamer
// Holds one decoded block and emits its sixteen pixels in row-major order
// through an output register, one pixel per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bctd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            blk_valid,
  output logic            blk_ready,
  input  bctd_pkg::blk_t  blk,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      pixel_row,
  output logic [1:0]      pixel_column,
  output logic [15:0]     pixel_color,
  output logic [7:0]      pixel_alpha,
  output logic            last_pixel
);

  bctd_pkg::blk_t  cur;
  logic            cur_valid;
  logic [3:0]      cnt;
  logic            load;
  logic            cnt_end;
  logic            take;
  logic [1:0]      ci;
  logic [3:0]      a4;
  logic [2:0]      ai;
  logic [5:0]      ai_pos;
  logic [7:0]      alpha;

  // The output register loads when empty or being taken.
  assign load      = !out_valid || out_ready;
  assign cnt_end   = cnt == 4'hF;
  assign blk_ready = !cur_valid || (load && cnt_end);
  assign take      = blk_valid && blk_ready;

  // Per-pixel index extraction.
  assign ci     = cur.cidx[{cnt, 1'b0} +: 2];
  assign a4     = cur.aw[{cnt, 2'b00} +: 4];
  assign ai_pos = 6'd16 + {2'd0, cnt} + {1'b0, cnt, 1'b0};
  assign ai     = cur.aw[ai_pos +: 3];

  // Alpha selection by block format.
  always_comb begin
    case (cur.kind)
      bctd_pkg::KIND_BC1: alpha = (cur.three_mode && ci == 2'd3) ? 8'd0 : 8'd255;
      bctd_pkg::KIND_BC2: alpha = {a4, a4};
      default:            alpha = cur.apal[ai];
    endcase
  end

  // Control: current block, pixel counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cur_valid <= 1'b1;
      end else if (load && cur_valid && cnt_end) begin
        cur_valid <= 1'b0;
      end
      if (load && cur_valid) begin
        cnt <= cnt + 1'b1;
      end
      if (load) begin
        out_valid <= cur_valid;
      end
    end
  end

  // Payload: block hold register and pixel output register.
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= blk;
    end
    if (load) begin
      pixel_row    <= cnt[3:2];
      pixel_column <= cnt[1:0];
      pixel_color  <= cur.pal[ci];
      pixel_alpha  <= alpha;
      last_pixel   <= cnt_end;
    end
  end

  // A block part-way through its pixels is always held.
  assert property (@(posedge clk) disable iff (rst) (cnt != 4'h0) |-> cur_valid)
    else $error("bctd_back: pixel count without a block");

  // The sixteenth pixel leaves marked as the last.
  assert property (@(posedge clk) disable iff (rst)
      (load && cur_valid && cnt_end) |=> (out_valid && last_pixel))
    else $error("bctd_back: last pixel not marked");

  // A new block always starts at the first pixel.
  assert property (@(posedge clk) disable iff (rst) take |=> (cnt == 4'h0))
    else $error("bctd_back: block taken mid-stream");

endmodule

// File: rtl/bc_texture_block_decoder.sv
// ----------------------------------------------------------------------------
// bc_texture_block_decoder: BC1/BC2/BC3 texture block decoder
// Reset empties all stages and the queue. A block passes both front-end stages,
// the queue and the block hold register on its way to the output register.
// The pixel streamer sets the rate, one pixel per cycle unless the receiver
// stalls; the front end takes a block each cycle while the queue has room.
// ----------------------------------------------------------------------------
module bc_texture_block_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   kind,
  input  logic [15:0]  endpoint_a,
  input  logic [15:0]  endpoint_b,
  input  logic [31:0]  color_indices,
  input  logic [63:0]  alpha_word,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   pixel_row,
  output logic [1:0]   pixel_column,
  output logic [15:0]  pixel_color,
  output logic [7:0]   pixel_alpha,
  output logic         last_pixel
);

  logic            f_valid;
  logic            f_ready;
  bctd_pkg::blk_t  f_blk;
  logic            q_valid;
  logic            q_ready;
  bctd_pkg::blk_t  q_blk;

  // Front end: classify the block and build its palettes.
  bctd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .endpoint_a    (endpoint_a),
    .endpoint_b    (endpoint_b),
    .color_indices (color_indices),
    .alpha_word    (alpha_word),
    .blk_valid     (f_valid),
    .blk_ready     (f_ready),
    .blk           (f_blk)
  );

  // Queue of decoded blocks.
  bctd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_blk),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_blk)
  );

  // Back end: stream the pixels out.
  bctd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .blk_valid    (q_valid),
    .blk_ready    (q_ready),
    .blk          (q_blk),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .pixel_color  (pixel_color),
    .pixel_alpha  (pixel_alpha),
    .last_pixel   (last_pixel)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for bc_texture_block_decoder
// Drives compressed BC1/BC2/BC3 blocks through the valid/ready input and
// checks every decoded pixel against a predictor built into this bench.
// Both sides idle at random. The receiver also holds off once for a long
// stretch so that the decoder fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP      = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int PRINT_LIMIT  = 40;

  // One decoded pixel as the decoder should present it.
  typedef struct {
    logic [1:0]  row;
    logic [1:0]  column;
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        is_last;
  } pixel_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_ready;
  logic [1:0]   kind;
  logic [15:0]  endpoint_a;
  logic [15:0]  endpoint_b;
  logic [31:0]  color_indices;
  logic [63:0]  alpha_word;
  logic         out_valid;
  logic         out_ready;
  logic [1:0]   pixel_row;
  logic [1:0]   pixel_column;
  logic [15:0]  pixel_color;
  logic [7:0]   pixel_alpha;
  logic         last_pixel;

  pixel_t pending_pixels[$];
  int     mismatch_count = 0;
  int     pixels_checked = 0;
  int     cycle_count = 0;
  bit     sender_gaps_on = 1'b1;
  bit     receiver_stalls_on = 1'b1;
  bit     hold_request = 1'b0;

  bc_texture_block_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .endpoint_a    (endpoint_a),
    .endpoint_b    (endpoint_b),
    .color_indices (color_indices),
    .alpha_word    (alpha_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_row     (pixel_row),
    .pixel_column  (pixel_column),
    .pixel_color   (pixel_color),
    .pixel_alpha   (pixel_alpha),
    .last_pixel    (last_pixel)
  );

  // Free-running 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit, so that a hung handshake cannot stall the run for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Per-channel weighted mix of two RGB565 colours with a truncating divide.
  function automatic logic [15:0] blend_565(input logic [15:0] c0, input logic [15:0] c1,
                                            input int w0, input int w1, input int dv);
    int r;
    int g;
    int b;
    r = (int'(c0[15:11]) * w0 + int'(c1[15:11]) * w1) / dv;
    g = (int'(c0[10:5]) * w0 + int'(c1[10:5]) * w1) / dv;
    b = (int'(c0[4:0]) * w0 + int'(c1[4:0]) * w1) / dv;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Works out the sixteen pixels of one block and queues them in order.
  task automatic predict_pixels(input logic [1:0] blk_kind, input logic [15:0] ea,
                                input logic [15:0] eb, input logic [31:0] cidx,
                                input logic [63:0] aw);
    logic [15:0] palette[4];
    logic [7:0]  alpha_palette[8];
    logic        three_colour;
    logic [1:0]  ci;
    logic [3:0]  a4;
    int          a0;
    int          a1;
    int          step;
    pixel_t      px;
    three_colour = (blk_kind == bctd_pkg::KIND_BC1) && !(ea > eb);
    palette[0] = ea;
    palette[1] = eb;
    if (three_colour) begin
      palette[2] = blend_565(ea, eb, 1, 1, 2);
      palette[3] = 16'h0000;
    end else begin
      palette[2] = blend_565(ea, eb, 2, 1, 3);
      palette[3] = blend_565(ea, eb, 1, 2, 3);
    end

    // BC3 alpha palette: six interpolated steps, or four plus 0 and 255.
    a0 = int'(aw[7:0]);
    a1 = int'(aw[15:8]);
    alpha_palette[0] = aw[7:0];
    alpha_palette[1] = aw[15:8];
    if (a0 > a1) begin
      for (step = 1; step <= 6; step++)
        alpha_palette[step + 1] = 8'(((7 - step) * a0 + step * a1) / 7);
    end else begin
      for (step = 1; step <= 4; step++)
        alpha_palette[step + 1] = 8'(((5 - step) * a0 + step * a1) / 5);
      alpha_palette[6] = 8'd0;
      alpha_palette[7] = 8'd255;
    end

    for (int p = 0; p < 16; p++) begin
      ci = cidx[2 * p +: 2];
      px.row = 2'(p / 4);
      px.column = 2'(p % 4);
      px.color = palette[ci];
      px.is_last = (p == 15);
      case (blk_kind)
        bctd_pkg::KIND_BC1: begin
          px.alpha = (three_colour && ci == 2'd3) ? 8'd0 : 8'd255;
        end
        bctd_pkg::KIND_BC2: begin
          a4 = aw[4 * p +: 4];
          px.alpha = {a4, a4};
        end
        default: begin
          px.alpha = alpha_palette[aw[16 + 3 * p +: 3]];
        end
      endcase
      pending_pixels.push_back(px);
    end
  endtask

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string field_name, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("pixel %0d: %s is 0x%0h, expected 0x%0h", pixels_checked, field_name,
               got, want);
    mismatch_count++;
  endtask

  // Sends one block: an optional random gap, then valid until accepted.
  task automatic send_block(input logic [1:0] blk_kind, input logic [15:0] ea,
                            input logic [15:0] eb, input logic [31:0] cidx,
                            input logic [63:0] aw);
    int gap;
    gap = sender_gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= blk_kind;
    endpoint_a <= ea;
    endpoint_b <= eb;
    color_indices <= cidx;
    alpha_word <= aw;
    do @(posedge clk); while (!in_ready);
    predict_pixels(blk_kind, ea, eb, cidx, aw);
  endtask

  // Sends one random block, at times with equal or extreme endpoints or equal alphas.
  task automatic send_random_block();
    logic [15:0] ea;
    logic [15:0] eb;
    logic [63:0] aw;
    int          pick;
    ea = 16'($urandom);
    eb = 16'($urandom);
    pick = $urandom_range(9, 0);
    if (pick == 0)
      eb = ea;
    else if (pick == 1) begin
      ea = $urandom_range(1, 0) ? 16'hffff : 16'h0000;
      eb = $urandom_range(1, 0) ? 16'hffff : 16'h0000;
    end
    aw = {$urandom, $urandom};
    if ($urandom_range(7, 0) == 0)
      aw[15:8] = aw[7:0];
    send_block(2'($urandom_range(3, 0)), ea, eb, $urandom, aw);
  endtask

  // Stops sending and waits until every predicted pixel has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // BC1 in both colour modes, equal endpoints and the endpoint extremes.
  task automatic test_bc1_modes();
    send_block(bctd_pkg::KIND_BC1, 16'hf800, 16'h001f, 32'he4e4e4e4, {$urandom, $urandom});
    send_block(bctd_pkg::KIND_BC1, 16'h001f, 16'hf800, 32'he4e4e4e4, {$urandom, $urandom});
    send_block(bctd_pkg::KIND_BC1, 16'h7bef, 16'h7bef, 32'h1b1b1b1b, {$urandom, $urandom});
    send_block(bctd_pkg::KIND_BC1, 16'hffff, 16'h0000, 32'h1b1b1b1b,
               64'hffff_ffff_ffff_ffff);
    send_block(bctd_pkg::KIND_BC1, 16'h0000, 16'hffff, 32'hffffffff, 64'h0);
  endtask

  // BC2 explicit alpha; colour stays four-colour even with endpoints ascending.
  task automatic test_bc2_alpha();
    send_block(bctd_pkg::KIND_BC2, 16'h1234, 16'habcd, 32'he4e4e4e4,
               64'hfedc_ba98_7654_3210);
    send_block(bctd_pkg::KIND_BC2, 16'h0000, 16'h0000, 32'h00000000, 64'h0);
    send_block(bctd_pkg::KIND_BC2, 16'hffff, 16'hffff, 32'hffffffff,
               64'hffff_ffff_ffff_ffff);
  endtask

  // BC3 in both alpha modes, with every alpha index, and kind 3 as BC3.
  task automatic test_bc3_alpha();
    logic [47:0] ramp;
    for (int p = 0; p < 16; p++)
      ramp[3 * p +: 3] = 3'(p % 8);
    send_block(bctd_pkg::KIND_BC3, 16'h001f, 16'hf800, 32'he4e4e4e4, {ramp, 8'd20, 8'd200});
    send_block(bctd_pkg::KIND_BC3, 16'hf800, 16'h07e0, 32'h1b1b1b1b, {ramp, 8'd200, 8'd20});
    send_block(bctd_pkg::KIND_BC3, 16'h8410, 16'h8410, 32'he4e4e4e4, {ramp, 8'd128, 8'd128});
    send_block(bctd_pkg::KIND_BC3, 16'hffff, 16'h0000, 32'h5555aaaa, {ramp, 8'd0, 8'd255});
    send_block(bctd_pkg::KIND_BC3, 16'h0000, 16'hffff, 32'haaaa5555, {ramp, 8'd255, 8'd0});
    send_block(2'd3, 16'h4a69, 16'hc618, 32'he4e4e4e4, {16'($urandom), ramp[31:0],
               8'd10, 8'd90});
    send_block(2'd3, 16'h0841, 16'hf79e, 32'h1b1b1b1b, {~ramp, 8'd90, 8'd10});
  endtask

  // The bulk of the run, in stretches with different idling on each side.
  task automatic test_random_blocks();
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) begin
        sender_gaps_on = ((n / 50) % 4 == 0) || ((n / 50) % 4 == 2);
        receiver_stalls_on = ((n / 50) % 4 == 0) || ((n / 50) % 4 == 3);
      end
      send_random_block();
    end
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // The receiver holds off while blocks arrive back to back, so the input stalls.
  task automatic test_backpressure();
    wait_for_results();
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_random_block();
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // Short bursts, each followed by a pause until the decoder has emptied.
  task automatic test_pause_for_results();
    repeat (3) begin
      repeat (5) send_random_block();
      wait_for_results();
    end
  endtask

  // Receiver: a random stall before each pixel, or one long hold-off on request.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request)
        stall = HOLD_CYCLES;
      else
        stall = receiver_stalls_on ? $urandom_range(MAX_GAP, 0) : 0;
      hold_request = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, colour", 32'(pixel_color), 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_row !== want.row)
          report_mismatch("pixel_row", 32'(pixel_row), 32'(want.row));
        if (pixel_column !== want.column)
          report_mismatch("pixel_column", 32'(pixel_column), 32'(want.column));
        if (pixel_color !== want.color)
          report_mismatch("pixel_color", 32'(pixel_color), 32'(want.color));
        if (pixel_alpha !== want.alpha)
          report_mismatch("pixel_alpha", 32'(pixel_alpha), 32'(want.alpha));
        if (last_pixel !== want.is_last)
          report_mismatch("last_pixel", 32'(last_pixel), 32'(want.is_last));
      end
      pixels_checked++;
    end
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= bctd_pkg::KIND_BC1;
    endpoint_a <= 16'h0000;
    endpoint_b <= 16'h0000;
    color_indices <= 32'h0;
    alpha_word <= 64'h0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bc1_modes();
    test_bc2_alpha();
    test_bc3_alpha();
    test_random_blocks();
    test_backpressure();
    test_pause_for_results();
    wait_for_results();

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
